// ===== hdl/dkl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkl_pkg
// Shared types, constants and disk geometry functions of the darkest disk
// locator.
// ----------------------------------------------------------------------------
package dkl_pkg;

   localparam int PIXEL_WIDTH    = 8;
   localparam int COORD_WIDTH    = 8;
   localparam int SUM_OUT_WIDTH  = 15;
   localparam int CSR_DATA_WIDTH = 9;
   localparam int CSR_IDX_WIDTH  = 1;
   localparam int RES_DEPTH      = 8;
   localparam int MAX_RADIUS     = 16;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_REGION_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_REGION_HEIGHT = 1'b1;

   localparam logic [CSR_DATA_WIDTH-1:0] REGION_SIZE_RESET = 9'd256;

   typedef struct packed {
      logic                     found;
      logic [SUM_OUT_WIDTH-1:0] darkest_sum;
      logic [COORD_WIDTH-1:0]   center_y;
      logic [COORD_WIDTH-1:0]   center_x;
   } dkl_result_type;

   // largest |dy| inside the disk at horizontal offset dx
   function automatic int half_span(input int dx, input int radius);
      int h;
      h = 0;
      for (int y = 0; y <= MAX_RADIUS; y++) begin
         if (y <= radius && y * y + dx * dx <= radius * radius) begin
            h = y;
         end
      end
      return h;
   endfunction

   // number of pixels in the disk
   function automatic int disk_points(input int radius);
      int n;
      int a;
      n = 0;
      for (int dx = -MAX_RADIUS; dx <= MAX_RADIUS; dx++) begin
         a = (dx < 0) ? -dx : dx;
         if (a <= radius) begin
            n = n + 2 * half_span(a, radius) + 1;
         end
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/dkl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dkl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/dkl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkl_cell
// One column cell of the disk sum chain: adds its column partial to the
// running sum from its neighbor and hands the result on.
// ----------------------------------------------------------------------------
module dkl_cell #(
   parameter int SUM_WIDTH  = 16,
   parameter int PART_WIDTH = 12
) (
   input  wire logic                  clock,
   input  wire logic                  shift_en,
   input  wire logic [SUM_WIDTH-1:0]  acc_in,
   input  wire logic [PART_WIDTH-1:0] part_in,
   output logic      [SUM_WIDTH-1:0]  acc_out
);

   logic [SUM_WIDTH-1:0] acc_ff;
   logic [SUM_WIDTH-1:0] acc_in_next;

   assign acc_in_next = acc_in + SUM_WIDTH'(part_in);
   assign acc_out     = acc_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         acc_ff <= acc_in_next;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/dkl_result_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkl_result_queue
// Small result FIFO between the search pipeline and the result channel.
// ----------------------------------------------------------------------------
module dkl_result_queue #(
   parameter int DEPTH = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire dkl_pkg::dkl_result_type push_data,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output dkl_pkg::dkl_result_type      out_data
);
   import dkl_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   dkl_result_type mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff;
   logic [AW-1:0]  wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff;
   logic [AW-1:0]  rd_ptr_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic           pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/darkest_disk_locator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// darkest_disk_locator_top
// Finds the disk of radius RADIUS with the smallest pixel sum in a region.
//
// req_* takes one grey pixel per word, in raster order over a region of
// region_width x region_height pixels (csr index 0 and 1, 1 to 256 each).
// After the region's last pixel one word leaves on rsp_*: the darkest centre,
// its disk sum (saturated to 15 bits) and a found flag in rsp_tuser; found
// is 0 with zero data when no full disk fits in the region.
// One pixel is taken every cycle while req_tready is high. A pixel runs
// through a line-store read, a row-pair stage, a column-sum stage, the chain
// of 2*RADIUS+1 column cells and the compare stage, which pushes a finished
// region's result word into the queue. Results wait in an 8-word queue;
// req_tready drops only while 8 results are pending and the receiver stalls.
// The line store needs no clearing: only rows of the current region are read.
// Reset sets both sizes to 256, clears the counters, the search and the queue.
// ----------------------------------------------------------------------------
module darkest_disk_locator_top #(
   parameter int RADIUS     = 5,
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // configuration
   input  wire logic                                   csr_wr_en,
   input  wire logic [dkl_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  wire logic [dkl_pkg::CSR_DATA_WIDTH-1:0]     csr_wr_data,
   // pixels
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [7:0]                             req_tdata,  // [7:0] pixel
   // results
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // [7:0] center_x, [15:8] center_y, [30:16] darkest_sum, [31] zero
   output logic [31:0]                                 rsp_tdata,
   output logic                                        rsp_tuser   // [0] found
);
   import dkl_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int SW    = CW + 1;
   localparam int HW    = RW + 1;
   localparam int NCELL = 2 * RADIUS + 1;
   localparam int VW    = $clog2(NCELL * 255 + 1);
   localparam int SUMW  = $clog2(disk_points(RADIUS) * 255 + 1);
   localparam int PW    = $clog2(RES_DEPTH + 1);

   typedef struct packed {
      logic          last;
      logic          clear;
      logic          qualify;
      logic [CW-1:0] cx;
      logic [RW-1:0] cy;
   } stage_tag_type;

   // configuration registers
   logic [CSR_DATA_WIDTH-1:0] region_width_ff;
   logic [CSR_DATA_WIDTH-1:0] region_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_width_ff  <= REGION_SIZE_RESET;
         region_height_ff <= REGION_SIZE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_REGION_WIDTH:  region_width_ff  <= csr_wr_data;
            CSR_REGION_HEIGHT: region_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // front end: raster counters
   logic [SW-1:0]  width_eff;
   logic [HW-1:0]  height_eff;
   logic [CW-1:0]  col_ff;
   logic [CW-1:0]  col_in;
   logic [RW-1:0]  row_ff;
   logic [RW-1:0]  row_in;
   logic           accept;
   logic           wrap_col;
   logic [HW-1:0]  row_bump;
   logic           start_clear;
   logic [CW-1:0]  cur_col;
   logic [RW-1:0]  cur_row;
   logic [SW-1:0]  col_next;
   logic [HW-1:0]  row_next;
   logic           row_end;
   logic           region_end;
   stage_tag_type  front_tag;
   logic [PW-1:0]  pending_ff;
   logic [PW-1:0]  pending_in;
   logic           rsp_take;

   always_comb begin
      if (region_width_ff == '0) begin
         width_eff = SW'(1);
      end else if (32'(region_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = SW'(MAX_WIDTH);
      end else begin
         width_eff = SW'(region_width_ff);
      end
      if (region_height_ff == '0) begin
         height_eff = HW'(1);
      end else if (32'(region_height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = HW'(MAX_HEIGHT);
      end else begin
         height_eff = HW'(region_height_ff);
      end
   end

   assign req_tready = (pending_ff < PW'(RES_DEPTH));
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      wrap_col    = ({1'b0, col_ff} >= width_eff);
      cur_col     = wrap_col ? '0 : col_ff;
      row_bump    = wrap_col ? {1'b0, row_ff} + 1'b1 : {1'b0, row_ff};
      start_clear = (row_bump >= height_eff);
      cur_row     = start_clear ? '0 : row_bump[RW-1:0];
      col_next    = {1'b0, cur_col} + 1'b1;
      row_next    = {1'b0, cur_row} + 1'b1;
      row_end     = (col_next >= width_eff);
      region_end  = row_end && (row_next >= height_eff);
      col_in      = row_end ? '0 : col_next[CW-1:0];
      if (!row_end) begin
         row_in = cur_row;
      end else if (region_end) begin
         row_in = '0;
      end else begin
         row_in = row_next[RW-1:0];
      end
      front_tag.last    = region_end;
      front_tag.clear   = start_clear;
      front_tag.qualify = (32'(cur_col) >= 32'(2 * RADIUS)) &&
                          (32'(cur_row) >= 32'(2 * RADIUS));
      front_tag.cx      = cur_col - CW'(RADIUS);
      front_tag.cy      = cur_row - RW'(RADIUS);
   end

   assign rsp_take = rsp_tvalid && rsp_tready;

   always_comb begin
      case ({accept && region_end, rsp_take})
         2'b10:   pending_in = pending_ff + 1'b1;
         2'b01:   pending_in = pending_ff - 1'b1;
         default: pending_in = pending_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // stage 1: line store read data, cascade write
   logic                   s1_valid_ff;
   logic [PIXEL_WIDTH-1:0] s1_pixel_ff;
   logic [CW-1:0]          s1_col_ff;
   stage_tag_type          s1_tag_ff;
   logic [PIXEL_WIDTH-1:0] line_rd [2 * RADIUS];
   logic [PIXEL_WIDTH-1:0] col_pix [NCELL];

   for (genvar j = 0; j < 2 * RADIUS; j++) begin : g_line
      logic [PIXEL_WIDTH-1:0] line_wr;
      if (j == 0) begin : g_first
         assign line_wr = s1_pixel_ff;
      end else begin : g_next
         assign line_wr = line_rd[j-1];
      end
      dkl_ram #(
         .WIDTH (PIXEL_WIDTH),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (s1_valid_ff),
         .wr_addr (s1_col_ff),
         .wr_data (line_wr),
         .rd_en   (accept),
         .rd_addr (cur_col),
         .rd_data (line_rd[j])
      );
   end

   always_comb begin
      col_pix[0] = s1_pixel_ff;
      for (int i = 1; i < NCELL; i++) begin
         col_pix[i] = line_rd[i-1];
      end
   end

   // stage 2: symmetric row pairs of the column
   logic                   s2_valid_ff;
   logic [PIXEL_WIDTH-1:0] s2_center_ff;
   logic [PIXEL_WIDTH:0]   s2_pair_ff [RADIUS:1];
   logic [PIXEL_WIDTH:0]   s2_pair_in [RADIUS:1];
   stage_tag_type          s2_tag_ff;

   always_comb begin
      for (int h = 1; h <= RADIUS; h++) begin
         s2_pair_in[h] = (PIXEL_WIDTH + 1)'(col_pix[RADIUS - h]) +
                         (PIXEL_WIDTH + 1)'(col_pix[RADIUS + h]);
      end
   end

   // stage 3: column partial sums for every half height
   logic          s3_valid_ff;
   logic [VW-1:0] s3_vsum_ff [RADIUS + 1];
   logic [VW-1:0] s3_vsum_in [RADIUS + 1];
   stage_tag_type s3_tag_ff;

   always_comb begin
      s3_vsum_in[0] = VW'(s2_center_ff);
      for (int h = 1; h <= RADIUS; h++) begin
         s3_vsum_in[h] = s3_vsum_in[h-1] + VW'(s2_pair_ff[h]);
      end
   end

   // cell chain: oldest column offset in cell 0, newest in the last cell
   logic [SUMW-1:0] cell_acc [NCELL];

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      localparam int HALF = half_span((k < RADIUS) ? RADIUS - k : k - RADIUS, RADIUS);
      logic [SUMW-1:0] acc_from;
      if (k == 0) begin : g_head
         assign acc_from = '0;
      end else begin : g_link
         assign acc_from = cell_acc[k-1];
      end
      dkl_cell #(
         .SUM_WIDTH  (SUMW),
         .PART_WIDTH (VW)
      ) u_cell (
         .clock    (clock),
         .shift_en (s3_valid_ff),
         .acc_in   (acc_from),
         .part_in  (s3_vsum_ff[HALF]),
         .acc_out  (cell_acc[k])
      );
   end

   // stage 4: compare against the best centre
   logic            s4_valid_ff;
   stage_tag_type   s4_tag_ff;
   logic [SUMW-1:0] disk_sum;
   logic            have_best_ff;
   logic [SUMW-1:0] best_sum_ff;
   logic [CW-1:0]   best_col_ff;
   logic [RW-1:0]   best_row_ff;
   logic            have_eff;
   logic            better;
   logic            take;
   logic            new_have;
   logic [SUMW-1:0] new_sum;
   logic [CW-1:0]   new_col;
   logic [RW-1:0]   new_row;
   logic            push;
   dkl_result_type  push_data;
   dkl_result_type  head;

   assign disk_sum = cell_acc[NCELL-1];

   always_comb begin
      have_eff = have_best_ff && !s4_tag_ff.clear;
      better   = !have_eff || (disk_sum < best_sum_ff) ||
                 ((disk_sum == best_sum_ff) &&
                  ((s4_tag_ff.cx < best_col_ff) ||
                   ((s4_tag_ff.cx == best_col_ff) && (s4_tag_ff.cy < best_row_ff))));
      take     = s4_tag_ff.qualify && better;
      new_have = take || have_eff;
      new_sum  = take ? disk_sum : best_sum_ff;
      new_col  = take ? s4_tag_ff.cx : best_col_ff;
      new_row  = take ? s4_tag_ff.cy : best_row_ff;
      push     = s4_valid_ff && s4_tag_ff.last;
      push_data.found = new_have;
      if (new_have) begin
         push_data.center_x    = COORD_WIDTH'(new_col);
         push_data.center_y    = COORD_WIDTH'(new_row);
         push_data.darkest_sum = (32'(new_sum) > 32'(2 ** SUM_OUT_WIDTH - 1)) ?
                                 '1 : SUM_OUT_WIDTH'(new_sum);
      end else begin
         push_data.center_x    = '0;
         push_data.center_y    = '0;
         push_data.darkest_sum = '0;
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         have_best_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         if (s4_valid_ff) begin
            have_best_ff <= s4_tag_ff.last ? 1'b0 : new_have;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_tdata[PIXEL_WIDTH-1:0];
         s1_col_ff   <= cur_col;
         s1_tag_ff   <= front_tag;
      end
      if (s1_valid_ff) begin
         s2_center_ff <= col_pix[RADIUS];
         s2_pair_ff   <= s2_pair_in;
         s2_tag_ff    <= s1_tag_ff;
      end
      if (s2_valid_ff) begin
         s3_vsum_ff <= s3_vsum_in;
         s3_tag_ff  <= s2_tag_ff;
      end
      if (s3_valid_ff) begin
         s4_tag_ff <= s3_tag_ff;
      end
      if (s4_valid_ff) begin
         best_sum_ff <= new_sum;
         best_col_ff <= new_col;
         best_row_ff <= new_row;
      end
   end

   dkl_result_queue #(
      .DEPTH (RES_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = {1'b0, head.darkest_sum, head.center_y, head.center_x};
   assign rsp_tuser = head.found;

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PW'(RES_DEPTH))
      else $error("result reservations exceed queue depth");

   a_result_reserved: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != '0))
      else $error("result word shown without a reservation");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_tvalid)
      else $error("region result not presented after push");

endmodule
`default_nettype wire

// ===== verif/darkest_disk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// darkest_disk_checker
// Watches the configuration, pixel and result ports of the darkest disk
// locator. Every accepted pixel runs through a cycle-free model of the region
// scan. Each finished region queues its predicted result, and every result
// word is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module darkest_disk_checker #(
   parameter int RADIUS     = 5,
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [dkl_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [dkl_pkg::CSR_DATA_WIDTH-1:0] csr_wr_data,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [31:0]                        rsp_tdata,
   input  logic                               rsp_tuser,
   output int                                 errors,
   output int                                 pending,
   output int                                 results_seen,
   output int                                 found_seen
);
   import dkl_pkg::*;

   localparam int          WIN_ROWS = 2 * RADIUS + 1;
   localparam int unsigned SUM_CAP  = 2 ** SUM_OUT_WIDTH - 1;

   logic [7:0]                window_rows [WIN_ROWS][MAX_WIDTH];
   logic [CSR_DATA_WIDTH-1:0] width_reg;
   logic [CSR_DATA_WIDTH-1:0] height_reg;
   int unsigned               best_sum;
   int                        best_col;
   int                        best_row;
   int                        col_count;
   int                        row_count;
   bit                        have_best;
   dkl_result_type            due_results[$];

   function automatic int fit_size(input logic [CSR_DATA_WIDTH-1:0] v, input int limit);
      if (v == 0) begin
         return 1;
      end
      if (v > limit) begin
         return limit;
      end
      return int'(v);
   endfunction

   function automatic void restart_search();
      best_sum  = '1;
      best_col  = 0;
      best_row  = 0;
      have_best = 1'b0;
   endfunction

   function automatic int unsigned disk_total(input int cx, input int cy);
      int unsigned acc;
      acc = 0;
      for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
         for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
            if (dx * dx + dy * dy <= RADIUS * RADIUS) begin
               acc += window_rows[(cy + dy) % WIN_ROWS][cx + dx];
            end
         end
      end
      return acc;
   endfunction

   // advance the raster scan by one pixel; returns 1 when the region closes
   function automatic bit advance_scan(input logic [7:0] pix, output dkl_result_type res);
      int          w;
      int          h;
      int          c;
      int          r;
      int          cx;
      int          cy;
      int unsigned s;
      bit          better;
      w   = fit_size(width_reg, MAX_WIDTH);
      h   = fit_size(height_reg, MAX_HEIGHT);
      res = '0;
      if (col_count >= w) begin
         col_count = 0;
         row_count++;
      end
      if (row_count >= h) begin
         row_count = 0;
         restart_search();
      end
      c = col_count;
      r = row_count;
      window_rows[r % WIN_ROWS][c] = pix;
      if (r >= 2 * RADIUS && c >= 2 * RADIUS) begin
         cx     = c - RADIUS;
         cy     = r - RADIUS;
         s      = disk_total(cx, cy);
         better = !have_best || s < best_sum ||
                  (s == best_sum && (cx < best_col || (cx == best_col && cy < best_row)));
         if (better) begin
            best_sum  = s;
            best_col  = cx;
            best_row  = cy;
            have_best = 1'b1;
         end
      end
      col_count = c + 1;
      if (col_count >= w) begin
         col_count = 0;
         row_count = r + 1;
         if (row_count >= h) begin
            if (have_best) begin
               res.found       = 1'b1;
               res.center_x    = best_col[COORD_WIDTH-1:0];
               res.center_y    = best_row[COORD_WIDTH-1:0];
               res.darkest_sum = SUM_OUT_WIDTH'((best_sum > SUM_CAP) ? SUM_CAP : best_sum);
            end
            row_count = 0;
            restart_search();
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void flag_field(input string field, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch_channels
      dkl_result_type predicted;
      dkl_result_type observed;
      if (reset) begin
         restart_search();
         col_count  = 0;
         row_count  = 0;
         width_reg  = REGION_SIZE_RESET;
         height_reg = REGION_SIZE_RESET;
         due_results.delete();
         errors       = 0;
         results_seen = 0;
         found_seen   = 0;
         pending     <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_REGION_WIDTH:  width_reg  = csr_wr_data;
               CSR_REGION_HEIGHT: height_reg = csr_wr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (advance_scan(req_tdata, predicted)) begin
               due_results.push_back(predicted);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            observed.center_x    = rsp_tdata[7:0];
            observed.center_y    = rsp_tdata[15:8];
            observed.darkest_sum = rsp_tdata[30:16];
            observed.found       = rsp_tuser;
            results_seen++;
            if (due_results.size() == 0) begin
               errors++;
               $display("%0t ns: result word with none expected, expected none, got %h/%0b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               predicted = due_results.pop_front();
               if (predicted.found) begin
                  found_seen++;
               end
               flag_field("center_x", int'(predicted.center_x), int'(observed.center_x));
               flag_field("center_y", int'(predicted.center_y), int'(observed.center_y));
               flag_field("darkest_sum", int'(predicted.darkest_sum),
                          int'(observed.darkest_sum));
               flag_field("found", int'(predicted.found), int'(observed.found));
            end
         end
         pending <= due_results.size();
      end
   end

endmodule

// ===== verif/tb_darkest_disk_locator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_darkest_disk_locator_top
// Streams whole regions of grey pixels into the darkest disk locator under
// random source gaps and result stalls. Sizes cover the register extremes,
// regions too small for a disk, flat regions full of ties and random content.
// The checker predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_darkest_disk_locator_top;
   import dkl_pkg::*;

   localparam int FLUSH_CYCLES = 8;
   localparam int QUIET_LIMIT  = 2000;
   localparam int TOTAL_PIXELS = 1550;

   typedef enum int {FILL_NOISE, FILL_SPOTS, FILL_BITS, FILL_FLAT} fill_kind_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      csr_wr_en   = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]  csr_index   = CSR_REGION_WIDTH;
   logic [CSR_DATA_WIDTH-1:0] csr_wr_data = '0;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata   = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [31:0]               rsp_tdata;
   logic                      rsp_tuser;

   int errors;
   int pending;
   int results_seen;
   int found_seen;
   int pixels_sent = 0;
   int sizes_run   = 0;
   int req_max     = 0;
   int rsp_max     = 0;
   int rsp_stall   = 0;
   int quiet       = 0;
   int region_w    = 256;
   int region_h    = 256;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   darkest_disk_locator_top DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   darkest_disk_checker disk_check (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .errors       (errors),
      .pending      (pending),
      .results_seen (results_seen),
      .found_seen   (found_seen)
   );

   // result side: stall a random number of cycles after each word
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         rsp_stall = $urandom_range(0, rsp_max);
      end else if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
      end
      rsp_tready <= (rsp_stall == 0);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("tb_darkest_disk_locator_top NOT OK");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic int fit_size(input logic [CSR_DATA_WIDTH-1:0] v);
      return (v == 0) ? 1 : ((v > 256) ? 256 : v);
   endfunction

   function automatic logic [7:0] fill_value(input fill_kind_type kind, input logic [7:0] level);
      case (kind)
         FILL_NOISE: return 8'($urandom_range(0, 255));
         FILL_SPOTS: return ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 40))
                                                         : 8'($urandom_range(180, 255));
         FILL_BITS:  return level ^ 8'($urandom_range(0, 1));
         default:    return level;
      endcase
   endfunction

   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // hold off until every result is back and the pipeline has emptied
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   task automatic set_region(input logic [CSR_DATA_WIDTH-1:0] w_raw,
                             input logic [CSR_DATA_WIDTH-1:0] h_raw);
      settle();
      write_csr(CSR_REGION_WIDTH, w_raw);
      write_csr(CSR_REGION_HEIGHT, h_raw);
      region_w = fit_size(w_raw);
      region_h = fit_size(h_raw);
      sizes_run++;
   endtask

   task automatic send_pixel(input logic [7:0] pix);
      int gap;
      gap = $urandom_range(0, req_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   task automatic send_regions(input int count, input fill_kind_type kind,
                               input logic [7:0] level);
      for (int n = 0; n < count; n++) begin
         for (int p = 0; p < region_w * region_h; p++) begin
            send_pixel(fill_value(kind, level));
         end
      end
   endtask

   function automatic int pick_idle();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 4;
         default: return 19;
      endcase
   endfunction

   initial begin : stimulus
      int                        pick;
      int                        count;
      logic [CSR_DATA_WIDTH-1:0] w_raw;
      logic [CSR_DATA_WIDTH-1:0] h_raw;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // full-width single row on the reset width
      req_max = 2;
      rsp_max = 3;
      settle();
      write_csr(CSR_REGION_HEIGHT, 9'd1);
      region_w = 256;
      region_h = 1;
      sizes_run++;
      send_regions(1, FILL_NOISE, 8'd0);

      // oversized registers clamp to the maximum
      set_region(9'd1, 9'd511);
      send_regions(1, FILL_NOISE, 8'd0);
      set_region(9'd511, 9'd1);
      send_regions(1, FILL_NOISE, 8'd0);

      // zero sizes act as 1x1, back to back against a slow receiver
      req_max = 0;
      rsp_max = 19;
      set_region(9'd0, 9'd0);
      send_regions(16, FILL_NOISE, 8'd0);

      // smallest region with a disk: brightest and darkest extremes
      rsp_max = 0;
      set_region(9'd11, 9'd11);
      send_regions(1, FILL_FLAT, 8'hff);
      send_regions(1, FILL_FLAT, 8'h00);

      // one short of a disk either way, then a flat field of ties
      req_max = 19;
      rsp_max = 19;
      set_region(9'd10, 9'd12);
      send_regions(1, FILL_NOISE, 8'd0);
      set_region(9'd12, 9'd10);
      send_regions(1, FILL_NOISE, 8'd0);
      set_region(9'd12, 9'd12);
      send_regions(1, FILL_FLAT, 8'd7);

      while (pixels_sent < TOTAL_PIXELS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            w_raw = CSR_DATA_WIDTH'($urandom_range(11, 24));
            h_raw = CSR_DATA_WIDTH'($urandom_range(11, 24));
            count = $urandom_range(1, 2);
         end else if (pick < 9) begin
            w_raw = CSR_DATA_WIDTH'($urandom_range(0, 30));
            h_raw = CSR_DATA_WIDTH'($urandom_range(0, 30));
            count = $urandom_range(1, 2);
         end else begin
            w_raw = CSR_DATA_WIDTH'($urandom_range(0, 3));
            h_raw = CSR_DATA_WIDTH'($urandom_range(0, 3));
            count = $urandom_range(6, 20);
         end
         if (fit_size(w_raw) * fit_size(h_raw) * count > TOTAL_PIXELS - pixels_sent) begin
            count = 1;
         end
         req_max = pick_idle();
         rsp_max = pick_idle();
         set_region(w_raw, h_raw);
         send_regions(count, fill_kind_type'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)));
      end

      settle();
      repeat (16) @(posedge clock);
      $display("Streamed %0d pixels over %0d region sizes;", pixels_sent, sizes_run);
      $display("%0d result words checked, %0d found a disk.", results_seen, found_seen);
      if (errors == 0 && pending == 0) begin
         $display("tb_darkest_disk_locator_top OK");
      end else begin
         $display("tb_darkest_disk_locator_top NOT OK");
      end
      $finish;
   end

endmodule
